[hdl/sc_pkg.sv]
// Shared types, codes and microcode store for the stack calculator.
// Used by every module in hdl/; has no dependencies of its own.
`default_nettype none

package sc_pkg;

   localparam int WORD_W  = 32;
   localparam int OP_W    = 3;
   localparam int ST_W    = 3;
   localparam int DEPTH_W = 5;
   localparam int UPC_W   = 5;
   localparam int DCNT_W  = $clog2(WORD_W + 1);

   // instruction codes
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_POP  = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

   // status codes
   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
   localparam logic [ST_W-1:0] ST_FEW     = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
   localparam logic [ST_W-1:0] ST_DIVZERO = 3'd4;

   // next-address control
   localparam logic [2:0] JC_NEXT     = 3'd0;  // fall through
   localparam logic [2:0] JC_GOTO     = 3'd1;  // unconditional jump
   localparam logic [2:0] JC_WAIT_REQ = 3'd2;  // hold until an item arrives
   localparam logic [2:0] JC_WAIT_DIV = 3'd3;  // hold while divider busy
   localparam logic [2:0] JC_WAIT_OUT = 3'd4;  // hold until output register free
   localparam logic [2:0] JC_IF_DIV   = 3'd5;  // jump if opcode is divide
   localparam logic [2:0] JC_IF_BZERO = 3'd6;  // jump if right operand is zero
   localparam logic [2:0] JC_DISPATCH = 3'd7;  // jump on opcode and stack fill

   // result register source
   localparam logic [1:0] RS_HOLD  = 2'd0;
   localparam logic [1:0] RS_RDATA = 2'd1;
   localparam logic [1:0] RS_ALU   = 2'd2;
   localparam logic [1:0] RS_DIV   = 2'd3;

   // microcode addresses
   localparam logic [UPC_W-1:0] U_IDLE   = 5'd0;
   localparam logic [UPC_W-1:0] U_DISP   = 5'd1;
   localparam logic [UPC_W-1:0] U_PUSH   = 5'd2;
   localparam logic [UPC_W-1:0] U_POP    = 5'd3;
   localparam logic [UPC_W-1:0] U_ARD    = 5'd4;
   localparam logic [UPC_W-1:0] U_ALAT   = 5'd5;
   localparam logic [UPC_W-1:0] U_ALU    = 5'd6;
   localparam logic [UPC_W-1:0] U_WB     = 5'd7;
   localparam logic [UPC_W-1:0] U_DCHK   = 5'd8;
   localparam logic [UPC_W-1:0] U_DGO    = 5'd9;
   localparam logic [UPC_W-1:0] U_DWAIT  = 5'd10;
   localparam logic [UPC_W-1:0] U_DRES   = 5'd11;
   localparam logic [UPC_W-1:0] U_RESP   = 5'd12;
   localparam logic [UPC_W-1:0] U_EFULL  = 5'd13;
   localparam logic [UPC_W-1:0] U_EEMPTY = 5'd14;
   localparam logic [UPC_W-1:0] U_EFEW   = 5'd15;
   localparam logic [UPC_W-1:0] U_EDZ    = 5'd16;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] top_value;
      logic [ST_W-1:0]          status;
      logic [DEPTH_W-1:0]       depth;
   } rsp_type;

   // one control word per microcode step
   typedef struct packed {
      logic [2:0]       jump;
      logic [UPC_W-1:0] target;
      logic             req_ready;
      logic             ld_req;
      logic             rd_second;
      logic             ld_a;
      logic             ld_b;
      logic [1:0]       res_sel;
      logic             wr_push;
      logic             wr_res;
      logic             cnt_inc;
      logic             cnt_dec;
      logic             st_en;
      logic [ST_W-1:0]  st_val;
      logic             div_start;
      logic             rsp_load;
   } ctl_word_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            few;
      logic            b_zero;
      logic            out_free;
   } dp_flags_type;

   // microcode store
   function automatic ctl_word_type ucode_rom(input logic [UPC_W-1:0] upc);
      ctl_word_type w;
      w = '0;
      case (upc)
         U_IDLE: begin
            w.req_ready = 1'b1;
            w.ld_req    = 1'b1;
            w.jump      = JC_WAIT_REQ;
            w.target    = U_DISP;
         end
         U_DISP: begin
            w.jump = JC_DISPATCH;  // top entry read issued here
         end
         U_PUSH: begin
            w.wr_push = 1'b1;
            w.cnt_inc = 1'b1;
            w.jump    = JC_GOTO;
            w.target  = U_RESP;
         end
         U_POP: begin
            w.res_sel = RS_RDATA;
            w.cnt_dec = 1'b1;
            w.jump    = JC_GOTO;
            w.target  = U_RESP;
         end
         U_ARD: begin
            w.ld_b      = 1'b1;
            w.rd_second = 1'b1;
            w.jump      = JC_NEXT;
         end
         U_ALAT: begin
            w.ld_a   = 1'b1;
            w.jump   = JC_IF_DIV;
            w.target = U_DCHK;
         end
         U_ALU: begin
            w.res_sel = RS_ALU;
            w.jump    = JC_NEXT;
         end
         U_WB: begin
            w.wr_res  = 1'b1;
            w.cnt_dec = 1'b1;
            w.jump    = JC_GOTO;
            w.target  = U_RESP;
         end
         U_DCHK: begin
            w.jump   = JC_IF_BZERO;
            w.target = U_EDZ;
         end
         U_DGO: begin
            w.div_start = 1'b1;
            w.jump      = JC_NEXT;
         end
         U_DWAIT: begin
            w.jump   = JC_WAIT_DIV;
            w.target = U_DRES;
         end
         U_DRES: begin
            w.res_sel = RS_DIV;
            w.jump    = JC_GOTO;
            w.target  = U_WB;
         end
         U_RESP: begin
            w.rsp_load = 1'b1;
            w.jump     = JC_WAIT_OUT;
            w.target   = U_IDLE;
         end
         U_EFULL: begin
            w.st_en  = 1'b1;
            w.st_val = ST_FULL;
            w.jump   = JC_GOTO;
            w.target = U_RESP;
         end
         U_EEMPTY: begin
            w.st_en  = 1'b1;
            w.st_val = ST_EMPTY;
            w.jump   = JC_GOTO;
            w.target = U_RESP;
         end
         U_EFEW: begin
            w.st_en  = 1'b1;
            w.st_val = ST_FEW;
            w.jump   = JC_GOTO;
            w.target = U_RESP;
         end
         U_EDZ: begin
            w.st_en  = 1'b1;
            w.st_val = ST_DIVZERO;
            w.jump   = JC_GOTO;
            w.target = U_RESP;
         end
         default: begin
            w.jump   = JC_GOTO;
            w.target = U_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[hdl/sc_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on sc_pkg.
`default_nettype none

module sc_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 div_busy,
   input  wire sc_pkg::dp_flags_type flags,
   output sc_pkg::ctl_word_type      ctl
);

   logic [sc_pkg::UPC_W-1:0] upc_ff;
   logic [sc_pkg::UPC_W-1:0] upc_in;
   logic [sc_pkg::UPC_W-1:0] upc_inc;
   logic [sc_pkg::UPC_W-1:0] disp_tgt;

   assign ctl     = sc_pkg::ucode_rom(upc_ff);
   assign upc_inc = upc_ff + sc_pkg::UPC_W'(1);

   // decode jump: opcode together with stack fill
   always_comb begin
      if (flags.op == sc_pkg::OP_PUSH) begin
         disp_tgt = flags.full ? sc_pkg::U_EFULL : sc_pkg::U_PUSH;
      end else if (flags.op == sc_pkg::OP_POP) begin
         disp_tgt = flags.empty ? sc_pkg::U_EEMPTY : sc_pkg::U_POP;
      end else if (flags.op inside {[sc_pkg::OP_ADD:sc_pkg::OP_DIV]}) begin
         disp_tgt = flags.few ? sc_pkg::U_EFEW : sc_pkg::U_ARD;
      end else begin
         disp_tgt = sc_pkg::U_RESP;  // unused opcodes: plain ok reply
      end
   end

   // next step
   always_comb begin
      case (ctl.jump)
         sc_pkg::JC_NEXT:     upc_in = upc_inc;
         sc_pkg::JC_GOTO:     upc_in = ctl.target;
         sc_pkg::JC_WAIT_REQ: upc_in = req_valid ? ctl.target : upc_ff;
         sc_pkg::JC_WAIT_DIV: upc_in = div_busy ? upc_ff : ctl.target;
         sc_pkg::JC_WAIT_OUT: upc_in = flags.out_free ? ctl.target : upc_ff;
         sc_pkg::JC_IF_DIV:
            upc_in = (flags.op == sc_pkg::OP_DIV) ? ctl.target : upc_inc;
         sc_pkg::JC_IF_BZERO: upc_in = flags.b_zero ? ctl.target : upc_inc;
         sc_pkg::JC_DISPATCH: upc_in = disp_tgt;
         default:             upc_in = sc_pkg::U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= sc_pkg::U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

[hdl/sc_div.sv]
// Signed 32-bit divider, truncating, one quotient bit per cycle (restoring).
// Depends on sc_pkg.
`default_nettype none

module sc_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [sc_pkg::WORD_W-1:0] num,
   input  wire logic [sc_pkg::WORD_W-1:0] den,
   output logic                           busy,
   output logic [sc_pkg::WORD_W-1:0]      quot
);

   localparam int W  = sc_pkg::WORD_W;
   localparam int CW = sc_pkg::DCNT_W;

   logic [W-1:0]  rem_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  dmag_ff;
   logic          neg_ff;
   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [W:0]    shifted;
   logic [W+1:0]  diff;
   logic          ge;
   logic [W-1:0]  nmag;
   logic [W-1:0]  dmag;

   // operand magnitudes; minimum value maps to 2^31 unsigned
   assign nmag = num[W-1] ? (W'(0) - num) : num;
   assign dmag = den[W-1] ? (W'(0) - den) : den;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dmag_ff};
   assign ge      = ~diff[W+1];

   assign busy = busy_ff;
   assign quot = neg_ff ? (W'(0) - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= nmag;
         dmag_ff <= dmag;
         neg_ff  <= num[W-1] ^ den[W-1];
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[W-1:0] : shifted[W-1:0];
         quo_ff <= {quo_ff[W-2:0], ge};
      end
   end

endmodule

`default_nettype wire

[hdl/sc_dpath.sv]
// Datapath: stack memory, operand and result registers, ALU, output register.
// Depends on sc_pkg; driven by the control word from sc_seq.
`default_nettype none

module sc_dpath #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sc_pkg::ctl_word_type      ctl,
   input  wire logic                      req_valid,
   input  wire sc_pkg::req_type           req_data,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output sc_pkg::rsp_type                rsp_data,
   input  wire logic [sc_pkg::WORD_W-1:0] div_quot,
   output logic [sc_pkg::WORD_W-1:0]      div_num,
   output logic [sc_pkg::WORD_W-1:0]      div_den,
   output sc_pkg::dp_flags_type           flags
);

   localparam int W  = sc_pkg::WORD_W;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int DW = sc_pkg::DEPTH_W;

   logic [W-1:0]           mem [STACK_DEPTH];
   logic [W-1:0]           rdata_ff;
   logic [sc_pkg::OP_W-1:0] op_ff;
   logic [W-1:0]           val_ff;
   logic [W-1:0]           a_ff;
   logic [W-1:0]           b_ff;
   logic [W-1:0]           res_ff;
   logic [W-1:0]           res_in;
   logic [sc_pkg::ST_W-1:0] st_ff;
   logic [CW-1:0]          cnt_ff;
   logic [CW-1:0]          cnt_in;
   logic [CW-1:0]          cnt_m1;
   logic [CW-1:0]          cnt_m2;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic [W-1:0]           wr_data;
   logic                   wr_en;
   logic [W-1:0]           alu_out;
   logic                   accept;
   logic                   out_free;
   logic                   rsp_valid_ff;
   sc_pkg::rsp_type        rsp_data_ff;

   assign accept   = ctl.ld_req & req_valid;
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign cnt_m1   = cnt_ff - CW'(1);
   assign cnt_m2   = cnt_ff - CW'(2);

   // stack addressing: top is count-1, second is count-2
   assign rd_addr = ctl.rd_second ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
   assign wr_addr = ctl.wr_push ? cnt_ff[AW-1:0] : cnt_m2[AW-1:0];
   assign wr_data = ctl.wr_push ? val_ff : res_ff;
   assign wr_en   = ctl.wr_push | ctl.wr_res;

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // add / subtract / multiply, low word kept
   always_comb begin
      case (op_ff)
         sc_pkg::OP_ADD: alu_out = a_ff + b_ff;
         sc_pkg::OP_SUB: alu_out = a_ff - b_ff;
         sc_pkg::OP_MUL: alu_out = a_ff * b_ff;
         default:        alu_out = '0;
      endcase
   end

   // result register source
   always_comb begin
      if (accept) begin
         res_in = '0;
      end else begin
         case (ctl.res_sel)
            sc_pkg::RS_RDATA: res_in = rdata_ff;
            sc_pkg::RS_ALU:   res_in = alu_out;
            sc_pkg::RS_DIV:   res_in = div_quot;
            default:          res_in = res_ff;
         endcase
      end
   end

   // stack count
   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (ctl.cnt_dec) begin
         cnt_in = cnt_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // item capture, operands, status
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (accept) begin
         op_ff  <= req_data.opcode;
         val_ff <= req_data.push_value;
         st_ff  <= sc_pkg::ST_OK;
      end else if (ctl.st_en) begin
         st_ff <= ctl.st_val;
      end
      if (ctl.ld_a) begin
         a_ff <= rdata_ff;
      end
      if (ctl.ld_b) begin
         b_ff <= rdata_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load && out_free) begin
         rsp_data_ff.top_value <= res_ff;
         rsp_data_ff.status    <= st_ff;
         rsp_data_ff.depth     <= DW'(cnt_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign div_num   = a_ff;
   assign div_den   = b_ff;

   assign flags.op       = op_ff;
   assign flags.full     = (cnt_ff == CW'(STACK_DEPTH));
   assign flags.empty    = (cnt_ff == '0);
   assign flags.few      = (cnt_ff < CW'(2));
   assign flags.b_zero   = (b_ff == '0);
   assign flags.out_free = out_free;

endmodule

`default_nettype wire

[hdl/stack_calculator.sv]
// Integer stack calculator, top level.
// Depends on sc_pkg, sc_seq, sc_dpath and sc_div.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one instruction per item:
//   opcode and push_value. rsp channel (rsp_valid/rsp_ready/rsp_data) returns
//   exactly one item per instruction: top_value, status and the stack depth
//   after the instruction.
//   A microcoded sequencer runs each instruction one at a time; req_ready is
//   high only in the idle step. Steps after idle and dispatch, in order:
//     push, pop, push when full, pop when empty, too few operands: own step,
//     response; unused opcodes: response; add, subtract, multiply: operand
//     reads, ALU, write-back, response; divide by zero: operand reads, zero
//     check, error, response; divide: operand reads, zero check, start, 32
//     one-bit divider steps, result, write-back, response.
//   The rate is set by these steps and, for divide, by the radix-2 divider.
//   The result is written to an output register, so the next item is
//   accepted while rsp_valid waits on a stalled receiver; a further result
//   waits in the response step until that register drains.
//   Reset (synchronous, active high) empties the stack and clears rsp_valid.
`default_nettype none

module stack_calculator #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire sc_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output sc_pkg::rsp_type      rsp_data
);

   sc_pkg::ctl_word_type      ctl;
   sc_pkg::dp_flags_type      flags;
   logic                      div_busy;
   logic [sc_pkg::WORD_W-1:0] div_quot;
   logic [sc_pkg::WORD_W-1:0] div_num;
   logic [sc_pkg::WORD_W-1:0] div_den;

   assign req_ready = ctl.req_ready;

   sc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .div_busy  (div_busy),
      .flags     (flags),
      .ctl       (ctl)
   );

   sc_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .div_quot  (div_quot),
      .div_num   (div_num),
      .div_den   (div_den),
      .flags     (flags)
   );

   sc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot)
   );

`ifndef SYNTHESIS
   // one instruction at a time: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous instruction still running");

   // no new item while a division is in flight
   assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !req_ready)
      else $error("input ready during division");

   // divider is only started when idle, and never on a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      ctl.div_start |-> (!div_busy && !flags.b_zero))
      else $error("divider started while busy or on zero divisor");

   // every error reply carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != sc_pkg::ST_OK) |-> (rsp_data.top_value == '0))
      else $error("error item with non-zero value");
`endif

endmodule

`default_nettype wire
